[hdl/cpcc_pkg.sv]
// Shared widths and constants for the capsule pair collision check core.
// No dependencies; imported by the core module.
`default_nettype none
package cpcc_pkg;
  localparam int COORD_WIDTH_DEF = 24;  // default coordinate width on the port
  localparam int CORE_WIDTH      = 24;  // stored coordinate width
  localparam int DIFF_WIDTH      = 25;  // segment directions and offset
  localparam int DOT_WIDTH       = 52;  // dot products of differences
  localparam int OP_WIDTH        = 56;  // multiplier operand width
  localparam int ACC_WIDTH       = 112; // products, numerators, remainders
  localparam int FRAC_BITS       = 28;  // fraction bits of s and t
  localparam int PAR_WIDTH       = FRAC_BITS + 1;
  localparam int RADIUS_WIDTH    = 20;
  localparam int MARGIN_WIDTH    = 21;
  localparam int CLEAR_WIDTH     = 26;
  localparam int Q6_WIDTH        = 34;  // difference component in 1/64 units
  localparam int SQ_WIDTH        = 64;  // sum of squares and root
  localparam int DIST_WIDTH      = 27;
  localparam int M_DATA_WIDTH    = 32;
endpackage
`default_nettype wire

[hdl/capsule_pair_collision_check_core.sv]
// Capsule pair collision check: closest points of two segments, distance, clearance.
// Slot 0 requests store a capsule. A slot 1 request runs from acceptance to result
// through 24 to 29 products on a shift-add multiplier that steps through the second
// operand bit by bit, up to two 28-step divisions and a 32-step root.
// One request at a time; the result waits in an output register.
// rst (synchronous) clears the sequencer, the held capsule and the margin.
// Depends on cpcc_pkg.
`default_nettype none
module capsule_pair_collision_check_core #(
  parameter int COORD_WIDTH = cpcc_pkg::COORD_WIDTH_DEF,
  localparam int S_DATA_WIDTH = ((6 * COORD_WIDTH + cpcc_pkg::RADIUS_WIDTH + 7) / 8) * 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, radius, zero fill
  input  wire logic [S_DATA_WIDTH-1:0]              s_tdata,
  // slot
  input  wire logic [0:0]                           s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // clearance, colliding, zero fill
  output logic [cpcc_pkg::M_DATA_WIDTH-1:0]         m_tdata,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [cpcc_pkg::MARGIN_WIDTH-1:0]    cfg_wr_data
);
  import cpcc_pkg::*;

  localparam int PRE_SHIFT = (COORD_WIDTH > CORE_WIDTH) ? COORD_WIDTH - CORE_WIDTH : 0;
  localparam int CL_WIDTH  = DIST_WIDTH + PRE_SHIFT + 2;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SETUP  = 5'd1;
  localparam logic [4:0] S_DOT    = 5'd2;
  localparam logic [4:0] S_DOTACC = 5'd3;
  localparam logic [4:0] S_CASE   = 5'd4;
  localparam logic [4:0] S_AE     = 5'd5;
  localparam logic [4:0] S_BB     = 5'd6;
  localparam logic [4:0] S_BF     = 5'd7;
  localparam logic [4:0] S_CE     = 5'd8;
  localparam logic [4:0] S_NUMT0  = 5'd9;
  localparam logic [4:0] S_NUMT1  = 5'd10;
  localparam logic [4:0] S_W0     = 5'd11;
  localparam logic [4:0] S_W1     = 5'd12;
  localparam logic [4:0] S_W2     = 5'd13;
  localparam logic [4:0] S_W3     = 5'd14;
  localparam logic [4:0] S_SQRT   = 5'd15;
  localparam logic [4:0] S_OUT    = 5'd16;
  localparam logic [4:0] S_MULLD  = 5'd17;
  localparam logic [4:0] S_MUL    = 5'd18;
  localparam logic [4:0] S_DIVCHK = 5'd19;
  localparam logic [4:0] S_DIV    = 5'd20;

  localparam logic [PAR_WIDTH-1:0] ONE_Q = PAR_WIDTH'(1) << FRAC_BITS;

  // sequencer
  logic [4:0] st;
  logic [4:0] ret;

  // held and current capsules, margin
  logic signed [CORE_WIDTH-1:0]   held_pt [6];
  logic [RADIUS_WIDTH-1:0]        held_rad;
  logic signed [CORE_WIDTH-1:0]   cur_pt [6];
  logic [RADIUS_WIDTH-1:0]        cur_rad;
  logic signed [MARGIN_WIDTH-1:0] margin;

  // segment data
  logic signed [DIFF_WIDTH-1:0] d1 [3];
  logic signed [DIFF_WIDTH-1:0] d2 [3];
  logic signed [DIFF_WIDTH-1:0] rv [3];
  logic signed [DOT_WIDTH-1:0]  dots [5];
  logic [2:0]                   grp;
  logic [1:0]                   ci;
  logic signed [ACC_WIDTH-1:0]  acc;
  logic signed [ACC_WIDTH-1:0]  tmp;
  logic signed [ACC_WIDTH-1:0]  den_keep;
  logic [PAR_WIDTH-1:0]         s_par;
  logic [PAR_WIDTH-1:0]         t_par;

  // shift-add multiplier
  logic signed [OP_WIDTH-1:0]  mx;
  logic signed [OP_WIDTH-1:0]  my;
  logic [ACC_WIDTH-1:0]        ma;
  logic [OP_WIDTH-1:0]         mb;
  logic [ACC_WIDTH-1:0]        mag;
  logic                        mneg;
  logic signed [ACC_WIDTH-1:0] prod;

  // restoring divider
  logic signed [ACC_WIDTH-1:0] dnum;
  logic signed [ACC_WIDTH-1:0] dden;
  logic [ACC_WIDTH-1:0]        drem;
  logic [FRAC_BITS-1:0]        dq;
  logic [4:0]                  dcnt;
  logic                        to_t;

  // square root
  logic [SQ_WIDTH-1:0] sx;
  logic [SQ_WIDTH-1:0] sres;
  logic [SQ_WIDTH-1:0] sbit;
  logic [SQ_WIDTH-1:0] sq;

  // input unpacking, wide coordinates reduced to the core width
  logic signed [CORE_WIDTH-1:0] in_pt [6];
  logic [RADIUS_WIDTH-1:0]      in_rad;

  for (genvar gv = 0; gv < 6; gv++) begin : g_pt
    logic signed [COORD_WIDTH-1:0] raw;
    assign raw = s_tdata[gv*COORD_WIDTH +: COORD_WIDTH];
    if (COORD_WIDTH > CORE_WIDTH) begin : g_wide
      assign in_pt[gv] = CORE_WIDTH'(raw >>> PRE_SHIFT);
    end else begin : g_narrow
      assign in_pt[gv] = CORE_WIDTH'(raw);
    end
  end
  assign in_rad = s_tdata[6*COORD_WIDTH +: RADIUS_WIDTH];

  assign s_tready = (st == S_IDLE);

  // named dot products
  logic signed [DOT_WIDTH-1:0] dot_a, dot_b, dot_c, dot_e, dot_f;
  assign dot_a = dots[0];
  assign dot_b = dots[1];
  assign dot_c = dots[2];
  assign dot_e = dots[3];
  assign dot_f = dots[4];

  // dot product operand selection
  logic signed [DIFF_WIDTH-1:0] op_u, op_v;
  always_comb begin
    op_u = (grp < 3'd3) ? d1[ci] : d2[ci];
    case (grp)
      3'd0:    op_v = d1[ci];
      3'd1:    op_v = d2[ci];
      3'd3:    op_v = d2[ci];
      default: op_v = rv[ci];
    endcase
  end

  // multiplier helpers
  logic [OP_WIDTH-1:0]         mx_abs, my_abs;
  logic signed [ACC_WIDTH-1:0] mag_signed;
  assign mx_abs     = mx[OP_WIDTH-1] ? OP_WIDTH'(-mx) : OP_WIDTH'(mx);
  assign my_abs     = my[OP_WIDTH-1] ? OP_WIDTH'(-my) : OP_WIDTH'(my);
  assign mag_signed = signed'(mag);

  // arithmetic on products
  logic signed [ACC_WIDTH-1:0] acc_sum, w_rnd, numt, dent, ab_diff;
  logic signed [Q6_WIDTH-1:0]  q6;
  assign acc_sum = acc + prod;
  assign w_rnd   = acc - prod + (ACC_WIDTH'(1) <<< (FRAC_BITS - 7));
  assign q6      = w_rnd[FRAC_BITS-6 +: Q6_WIDTH];
  assign numt    = prod + (ACC_WIDTH'(dot_f) <<< FRAC_BITS);
  assign dent    = ACC_WIDTH'(dot_e) <<< FRAC_BITS;
  assign ab_diff = tmp - prod;

  // divider step
  logic [ACC_WIDTH-1:0] rem2;
  logic                 div_ge;
  assign rem2   = {drem[ACC_WIDTH-2:0], 1'b0};
  assign div_ge = rem2 >= ACC_WIDTH'(dden);

  // square root step
  logic [SQ_WIDTH-1:0] trial;
  assign trial = sres + sbit;

  // clearance
  logic [DIST_WIDTH-1:0]       seg_len;
  logic signed [CL_WIDTH-1:0]  clr;
  logic                        coll;
  logic [CLEAR_WIDTH-1:0]      clr_sat;
  localparam logic signed [CL_WIDTH-1:0] CL_MAX = CL_WIDTH'((64'sd1 <<< (CLEAR_WIDTH - 1)) - 1);
  localparam logic signed [CL_WIDTH-1:0] CL_MIN = -CL_WIDTH'(64'sd1 <<< (CLEAR_WIDTH - 1));
  always_comb begin
    seg_len = DIST_WIDTH'((sres[DIST_WIDTH+5:0] + (DIST_WIDTH + 6)'(32)) >> 6);
    clr  = signed'(CL_WIDTH'(seg_len) << PRE_SHIFT) - signed'(CL_WIDTH'(held_rad))
           - signed'(CL_WIDTH'(cur_rad));
    coll = clr < CL_WIDTH'(margin);
    if (clr > CL_MAX) begin
      clr_sat = CL_MAX[CLEAR_WIDTH-1:0];
    end else if (clr < CL_MIN) begin
      clr_sat = CL_MIN[CLEAR_WIDTH-1:0];
    end else begin
      clr_sat = clr[CLEAR_WIDTH-1:0];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= '0;
    end else if (cfg_wr_en) begin
      margin <= signed'(cfg_wr_data);
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      m_tvalid <= 1'b0;
      held_rad <= '0;
      for (int k = 0; k < 6; k++) held_pt[k] <= '0;
    end else begin
      // result register: load from the sequencer, clear when taken
      if (st == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            if (!s_tuser[0]) begin
              for (int k = 0; k < 6; k++) held_pt[k] <= in_pt[k];
              held_rad <= in_rad;
            end else begin
              for (int k = 0; k < 6; k++) cur_pt[k] <= in_pt[k];
              cur_rad <= in_rad;
              st      <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          for (int k = 0; k < 3; k++) begin
            d1[k] <= DIFF_WIDTH'(held_pt[k+3]) - DIFF_WIDTH'(held_pt[k]);
            d2[k] <= DIFF_WIDTH'(cur_pt[k+3]) - DIFF_WIDTH'(cur_pt[k]);
            rv[k] <= DIFF_WIDTH'(held_pt[k]) - DIFF_WIDTH'(cur_pt[k]);
          end
          grp <= '0;
          ci  <= '0;
          acc <= '0;
          sq  <= '0;
          st  <= S_DOT;
        end
        // five dot products, three terms each
        S_DOT: begin
          mx  <= OP_WIDTH'(op_u);
          my  <= OP_WIDTH'(op_v);
          ret <= S_DOTACC;
          st  <= S_MULLD;
        end
        S_DOTACC: begin
          if (ci == 2'd2) begin
            dots[grp] <= acc_sum[DOT_WIDTH-1:0];
            acc       <= '0;
            ci        <= '0;
            if (grp == 3'd4) begin
              st <= S_CASE;
            end else begin
              grp <= grp + 3'd1;
              st  <= S_DOT;
            end
          end else begin
            acc <= acc_sum;
            ci  <= ci + 2'd1;
            st  <= S_DOT;
          end
        end
        // degenerate segments or the general solve
        S_CASE: begin
          ci <= '0;
          if (dot_a == '0 && dot_e == '0) begin
            s_par <= '0;
            t_par <= '0;
            st    <= S_W0;
          end else if (dot_a == '0) begin
            s_par <= '0;
            dnum  <= ACC_WIDTH'(dot_f);
            dden  <= ACC_WIDTH'(dot_e);
            to_t  <= 1'b1;
            ret   <= S_W0;
            st    <= S_DIVCHK;
          end else if (dot_e == '0) begin
            t_par <= '0;
            dnum  <= -ACC_WIDTH'(dot_c);
            dden  <= ACC_WIDTH'(dot_a);
            to_t  <= 1'b0;
            ret   <= S_W0;
            st    <= S_DIVCHK;
          end else begin
            mx  <= OP_WIDTH'(dot_a);
            my  <= OP_WIDTH'(dot_e);
            ret <= S_AE;
            st  <= S_MULLD;
          end
        end
        S_AE: begin
          tmp <= prod;
          mx  <= OP_WIDTH'(dot_b);
          my  <= OP_WIDTH'(dot_b);
          ret <= S_BB;
          st  <= S_MULLD;
        end
        S_BB: begin
          if (ab_diff == '0) begin
            s_par <= '0;
            st    <= S_NUMT0;
          end else begin
            den_keep <= ab_diff;
            mx       <= OP_WIDTH'(dot_b);
            my       <= OP_WIDTH'(dot_f);
            ret      <= S_BF;
            st       <= S_MULLD;
          end
        end
        S_BF: begin
          tmp <= prod;
          mx  <= OP_WIDTH'(dot_c);
          my  <= OP_WIDTH'(dot_e);
          ret <= S_CE;
          st  <= S_MULLD;
        end
        S_CE: begin
          dnum <= ab_diff;
          dden <= den_keep;
          to_t <= 1'b0;
          ret  <= S_NUMT0;
          st   <= S_DIVCHK;
        end
        // recompute t from s, clamp and recompute s where needed
        S_NUMT0: begin
          mx  <= OP_WIDTH'(dot_b);
          my  <= OP_WIDTH'(s_par);
          ret <= S_NUMT1;
          st  <= S_MULLD;
        end
        S_NUMT1: begin
          ret <= S_W0;
          st  <= S_DIVCHK;
          if (numt < 0) begin
            t_par <= '0;
            dnum  <= -ACC_WIDTH'(dot_c);
            dden  <= ACC_WIDTH'(dot_a);
            to_t  <= 1'b0;
          end else if (numt > dent) begin
            t_par <= ONE_Q;
            dnum  <= ACC_WIDTH'(dot_b) - ACC_WIDTH'(dot_c);
            dden  <= ACC_WIDTH'(dot_a);
            to_t  <= 1'b0;
          end else begin
            dnum <= numt;
            dden <= dent;
            to_t <= 1'b1;
          end
        end
        // closest-point difference, one component per pass
        S_W0: begin
          mx  <= OP_WIDTH'(s_par);
          my  <= OP_WIDTH'(d1[ci]);
          ret <= S_W1;
          st  <= S_MULLD;
        end
        S_W1: begin
          acc <= (ACC_WIDTH'(rv[ci]) <<< FRAC_BITS) + prod;
          mx  <= OP_WIDTH'(t_par);
          my  <= OP_WIDTH'(d2[ci]);
          ret <= S_W2;
          st  <= S_MULLD;
        end
        S_W2: begin
          mx  <= OP_WIDTH'(q6);
          my  <= OP_WIDTH'(q6);
          ret <= S_W3;
          st  <= S_MULLD;
        end
        S_W3: begin
          if (ci == 2'd2) begin
            sx   <= sq + prod[SQ_WIDTH-1:0];
            sres <= '0;
            sbit <= SQ_WIDTH'(1) << (SQ_WIDTH - 2);
            st   <= S_SQRT;
          end else begin
            sq <= sq + prod[SQ_WIDTH-1:0];
            ci <= ci + 2'd1;
            st <= S_W0;
          end
        end
        // floor square root, one result bit per cycle
        S_SQRT: begin
          if (sbit == '0) begin
            st <= S_OUT;
          end else begin
            if (sx >= trial) begin
              sx   <= sx - trial;
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= M_DATA_WIDTH'({coll, clr_sat});
            st       <= S_IDLE;
          end
        end
        // multiplier: load magnitudes, then one bit of my per cycle
        S_MULLD: begin
          ma   <= ACC_WIDTH'(mx_abs);
          mb   <= my_abs;
          mneg <= mx[OP_WIDTH-1] ^ my[OP_WIDTH-1];
          mag  <= '0;
          st   <= S_MUL;
        end
        S_MUL: begin
          if (mb == '0) begin
            prod <= mneg ? -mag_signed : mag_signed;
            st   <= ret;
          end else begin
            if (mb[0]) mag <= mag + ma;
            ma <= ma << 1;
            mb <= mb >> 1;
          end
        end
        // divider: clamp checks, then one quotient bit per cycle
        S_DIVCHK: begin
          if (dnum <= 0) begin
            if (to_t) t_par <= '0;
            else s_par <= '0;
            st <= ret;
          end else if (dnum >= dden) begin
            if (to_t) t_par <= ONE_Q;
            else s_par <= ONE_Q;
            st <= ret;
          end else begin
            drem <= ACC_WIDTH'(dnum);
            dq   <= '0;
            dcnt <= '0;
            st   <= S_DIV;
          end
        end
        S_DIV: begin
          drem <= div_ge ? rem2 - ACC_WIDTH'(dden) : rem2;
          dq   <= {dq[FRAC_BITS-2:0], div_ge};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'(FRAC_BITS - 1)) begin
            if (to_t) t_par <= {1'b0, dq[FRAC_BITS-2:0], div_ge};
            else s_par <= {1'b0, dq[FRAC_BITS-2:0], div_ge};
            st <= ret;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // a pair request keeps the block busy for at least the next cycle
  a_pair_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
    else $error("pair request did not start the sequencer");

  // a store request leaves the block ready again in the next cycle
  a_store_quick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser[0]) |=> s_tready)
    else $error("store request left the block busy");

  // divider never runs past its last quotient bit
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (st == S_DIV) |-> (dcnt < 5'(FRAC_BITS)))
    else $error("divider step count overran");

endmodule
`default_nettype wire
